@@ src/owbm_pkg.sv @@
package owbm_pkg;

  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_NUM = 8;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PHASE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  // Mode codes of a tick request
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BUS_RESET,
    CMD_WRITE_BYTE,
    CMD_READ_BYTE
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] reset_release;
    logic [CFG_W-1:0] fall_limit;
    logic [CFG_W-1:0] rise_limit;
    logic [CFG_W-1:0] short_phase;
    logic [CFG_W-1:0] long_phase;
    logic [CFG_W-1:0] read_sample;
    logic [CFG_W-1:0] read_tail;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ src/owbm_front.sv @@
module owbm_front
  import owbm_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] write_data_i,
  input  logic       line_level_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output item_t      item_o
);

  cmd_e cmd;

  always_comb begin
    unique case (mode_i)
      MODE_RESET: cmd = CMD_BUS_RESET;
      MODE_WRITE: cmd = CMD_WRITE_BYTE;
      MODE_READ:  cmd = CMD_READ_BYTE;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  assign item_o.cmd        = cmd;
  assign item_o.write_data = write_data_i;
  assign item_o.line_level = line_level_i;

endmodule

@@ src/owbm_queue.sv @@
module owbm_queue
  import owbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  localparam int unsigned Depth = 2;

  item_t      mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'(Depth));
  assign status_o.empty = (cnt_q == 2'd0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/owbm_engine.sv @@
module owbm_engine
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_empty_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       drive_low_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_value_o,
  output logic       presence_error_o
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RST_LOW    = 4'd1;
  localparam logic [3:0] PH_RST_REL    = 4'd2;
  localparam logic [3:0] PH_WATCH_FALL = 4'd3;
  localparam logic [3:0] PH_WATCH_RISE = 4'd4;
  localparam logic [3:0] PH_W_LOW      = 4'd5;
  localparam logic [3:0] PH_W_HIGH     = 4'd6;
  localparam logic [3:0] PH_R_LOW      = 4'd7;
  localparam logic [3:0] PH_R_WAIT     = 4'd8;
  localparam logic [3:0] PH_R_SAMPLE   = 4'd9;
  localparam logic [3:0] PH_R_TAIL     = 4'd10;

  logic [3:0]             phase_q, phase_d;
  logic [TIMER_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             send_q, send_d;
  logic [7:0]             recv_q, recv_d;
  logic                   err_q, err_d;
  logic                   drive, done, reached;
  logic [CFG_W-1:0]       len;

  logic                   out_valid_q;
  logic                   drive_q, busy_q, done_q, err_out_q;
  logic [7:0]             recv_out_q;

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    send_d   = send_q;
    recv_d   = recv_q;
    err_d    = err_q;
    drive    = 1'b0;
    done     = 1'b0;
    len      = CFG_W'(1);
    tick_inc = '0;
    reached  = 1'b0;

    // A command starts only from idle; its first tick runs below
    if (phase_d == PH_IDLE) begin
      unique case (item_i.cmd)
        CMD_BUS_RESET: begin
          phase_d = PH_RST_LOW;
          tick_d  = '0;
        end
        CMD_WRITE_BYTE: begin
          send_d  = item_i.write_data;
          bit_d   = 3'd0;
          phase_d = PH_W_LOW;
          tick_d  = '0;
        end
        CMD_READ_BYTE: begin
          recv_d  = 8'd0;
          bit_d   = 3'd0;
          phase_d = PH_R_LOW;
          tick_d  = '0;
        end
        default: ;
      endcase
    end

    if (phase_d != PH_IDLE) begin
      drive = (phase_d == PH_RST_LOW) || (phase_d == PH_W_LOW) || (phase_d == PH_R_LOW);
      tick_inc = tick_d + TIMER_WIDTH'(1);

      case (phase_d)
        PH_RST_LOW:    len = cfg_i.reset_low;
        PH_RST_REL:    len = cfg_i.reset_release;
        PH_WATCH_FALL: len = cfg_i.fall_limit;
        PH_WATCH_RISE: len = cfg_i.rise_limit;
        PH_W_LOW:      len = send_d[0] ? cfg_i.short_phase : cfg_i.long_phase;
        PH_W_HIGH:     len = send_d[0] ? cfg_i.long_phase : cfg_i.short_phase;
        PH_R_LOW:      len = cfg_i.short_phase;
        PH_R_WAIT:     len = cfg_i.read_sample;
        PH_R_TAIL:     len = cfg_i.read_tail;
        default:       len = CFG_W'(1);
      endcase
      reached = (tick_inc >= TIMER_WIDTH'(len));

      unique case (phase_d)
        PH_WATCH_FALL: begin
          if (!item_i.line_level) begin
            phase_d = PH_WATCH_RISE;
            tick_d  = '0;
          end else if (reached) begin
            err_d   = 1'b1;
            phase_d = PH_IDLE;
            tick_d  = '0;
            done    = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_WATCH_RISE: begin
          if (item_i.line_level) begin
            err_d   = 1'b0;
            phase_d = PH_IDLE;
            tick_d  = '0;
            done    = 1'b1;
          end else if (reached) begin
            err_d   = 1'b1;
            phase_d = PH_IDLE;
            tick_d  = '0;
            done    = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        PH_R_SAMPLE: begin
          if (item_i.line_level) begin
            recv_d[bit_d] = 1'b1;
          end
          tick_d = '0;
          if (cfg_i.read_tail != '0) begin
            phase_d = PH_R_TAIL;
          end else if (bit_d == 3'd7) begin
            bit_d   = 3'd0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            bit_d   = bit_d + 3'd1;
            phase_d = PH_R_LOW;
          end
        end
        default: begin
          // Timed phases: advance the counter and move on at the phase length
          tick_d = tick_inc;
          if (reached) begin
            tick_d = '0;
            unique case (phase_d)
              PH_RST_LOW: begin
                phase_d = (cfg_i.reset_release == '0) ? PH_WATCH_FALL : PH_RST_REL;
              end
              PH_RST_REL: phase_d = PH_WATCH_FALL;
              PH_W_LOW:   phase_d = PH_W_HIGH;
              PH_W_HIGH: begin
                send_d = {1'b0, send_d[7:1]};
                if (bit_d == 3'd7) begin
                  bit_d   = 3'd0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_d + 3'd1;
                  phase_d = PH_W_LOW;
                end
              end
              PH_R_LOW: begin
                phase_d = (cfg_i.read_sample == '0) ? PH_R_SAMPLE : PH_R_WAIT;
              end
              PH_R_WAIT:  phase_d = PH_R_SAMPLE;
              PH_R_TAIL: begin
                if (bit_d == 3'd7) begin
                  bit_d   = 3'd0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_d + 3'd1;
                  phase_d = PH_R_LOW;
                end
              end
              default:    phase_d = PH_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= 3'd0;
      send_q      <= 8'd0;
      recv_q      <= 8'd0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        send_q  <= send_d;
        recv_q  <= recv_d;
        err_q   <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      drive_q    <= drive;
      busy_q     <= (phase_d != PH_IDLE);
      done_q     <= done;
      recv_out_q <= recv_d;
      err_out_q  <= err_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_low_o      = drive_q;
  assign busy_res_o       = busy_q;
  assign done_res_o       = done_q;
  assign read_value_o     = recv_out_q;
  assign presence_error_o = err_out_q;

endmodule

@@ src/one_wire_bus_master_top.sv @@
// 1-Wire bus master stepped by one-microsecond tick requests. Each accepted tick
// (mode, write byte, sampled line level) yields exactly one result (drive low,
// busy, done pulse, read byte, presence error). Sustained rate is one tick per
// clock while results are taken: the engine steps the bus state once per tick;
// a tick passes through a queue entry, then the result register. The two-entry
// queue between decoder and engine plus the result register absorb stalls on
// either side, so the input keeps accepting while a result waits, until the
// queue is full. Configuration registers take effect on the next tick and
// should be written while the master is idle and all results have been taken.
module one_wire_bus_master_top
  import owbm_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 drive_low_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic [7:0]           read_value_o,
  output logic                 presence_error_o
);

  cfg_t      cfg_q;
  item_t     push_item, pop_item;
  logic      push, pop;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= CFG_W'(480);
      cfg_q.reset_release <= CFG_W'(15);
      cfg_q.fall_limit    <= CFG_W'(200);
      cfg_q.rise_limit    <= CFG_W'(240);
      cfg_q.short_phase   <= CFG_W'(2);
      cfg_q.long_phase    <= CFG_W'(60);
      cfg_q.read_sample   <= CFG_W'(12);
      cfg_q.read_tail     <= CFG_W'(50);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RESET_LOW:     cfg_q.reset_low     <= cfg_data_i;
        REG_RESET_RELEASE: cfg_q.reset_release <= cfg_data_i;
        REG_FALL_LIMIT:    cfg_q.fall_limit    <= cfg_data_i;
        REG_RISE_LIMIT:    cfg_q.rise_limit    <= cfg_data_i;
        REG_SHORT_PHASE:   cfg_q.short_phase   <= cfg_data_i;
        REG_LONG_PHASE:    cfg_q.long_phase    <= cfg_data_i;
        REG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data_i;
        REG_READ_TAIL:     cfg_q.read_tail     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  owbm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .write_data_i (write_data_i),
    .line_level_i (line_level_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (push_item)
  );

  owbm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  owbm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_empty_i        (q_status.empty),
    .item_i           (pop_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_low_o      (drive_low_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .read_value_o     (read_value_o),
    .presence_error_o (presence_error_o)
  );

`ifndef SYNTH
  a_done_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while operation still busy");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_low_o |-> busy_res_o)
    else $error("line driven low on the last tick of an operation");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("engine stepped without a queued request");

  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full && !pop |=> q_status.full)
    else $error("queue lost an entry");
`endif

endmodule

@@ test/owbm_result_check.sv @@
`timescale 1ns / 100ps
module owbm_result_check
  import owbm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 drive_low_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic [7:0]           read_value_i,
  input  logic                 presence_error_i,
  output int                   fail_cnt_o,
  output int                   owed_cnt_o
);

  localparam int REPORT_MAX = 10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RST_LOW,
    ST_RST_REL,
    ST_FALL_WATCH,
    ST_RISE_WATCH,
    ST_WR_LOW,
    ST_WR_HIGH,
    ST_RD_LOW,
    ST_RD_WAIT,
    ST_RD_SAMPLE,
    ST_RD_TAIL
  } bus_state_e;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_value;
    logic       presence_error;
  } bus_result_t;

  bus_state_e       st_q = ST_IDLE;
  logic [CFG_W-1:0] cnt_q = '0;
  logic [2:0]       bit_q = '0;
  logic [7:0]       tx_q = '0;
  logic [7:0]       rx_q = '0;
  logic             err_q = 1'b0;
  logic [CFG_W-1:0] cfg_q [CFG_NUM];
  bus_result_t      bus_result_q [$];
  int               fail_n = 0;
  int               owed_n = 0;

  assign fail_cnt_o = fail_n;
  assign owed_cnt_o = owed_n;

  function automatic void go_to(bus_state_e s);
    st_q  = s;
    cnt_q = '0;
  endfunction

  function automatic logic [CFG_W-1:0] phase_ticks(bus_state_e s);
    case (s)
      ST_RST_LOW: return cfg_q[REG_RESET_LOW];
      ST_RST_REL: return cfg_q[REG_RESET_RELEASE];
      ST_WR_LOW:  return tx_q[0] ? cfg_q[REG_SHORT_PHASE] : cfg_q[REG_LONG_PHASE];
      ST_WR_HIGH: return tx_q[0] ? cfg_q[REG_LONG_PHASE] : cfg_q[REG_SHORT_PHASE];
      ST_RD_LOW:  return cfg_q[REG_SHORT_PHASE];
      ST_RD_WAIT: return cfg_q[REG_READ_SAMPLE];
      ST_RD_TAIL: return cfg_q[REG_READ_TAIL];
      default:    return CFG_W'(1);
    endcase
  endfunction

  // Close one bit slot; return 1 when it was the last of the byte.
  function automatic logic slot_end(bus_state_e again);
    logic last;
    last  = (bit_q == 3'd7);
    bit_q = bit_q + 3'd1;
    if (last) go_to(ST_IDLE);
    else go_to(again);
    return last;
  endfunction

  function automatic void presence_end(logic err, ref bus_result_t res);
    err_q    = err;
    res.done = 1'b1;
    go_to(ST_IDLE);
  endfunction

  function automatic bus_result_t advance_bus(logic [1:0] mode, logic [7:0] wd, logic line);
    bus_result_t res;
    res = '0;
    if (st_q == ST_IDLE) begin
      case (mode)
        MODE_RESET: go_to(ST_RST_LOW);
        MODE_WRITE: begin
          tx_q  = wd;
          bit_q = '0;
          go_to(ST_WR_LOW);
        end
        MODE_READ: begin
          rx_q  = '0;
          bit_q = '0;
          go_to(ST_RD_LOW);
        end
        default: ;
      endcase
    end
    if (st_q != ST_IDLE) begin
      res.drive_low = (st_q == ST_RST_LOW) || (st_q == ST_WR_LOW) || (st_q == ST_RD_LOW);
      case (st_q)
        ST_FALL_WATCH: begin
          if (!line) begin
            go_to(ST_RISE_WATCH);
          end else begin
            cnt_q = cnt_q + CFG_W'(1);
            if (cnt_q >= cfg_q[REG_FALL_LIMIT]) presence_end(1'b1, res);
          end
        end
        ST_RISE_WATCH: begin
          if (line) begin
            presence_end(1'b0, res);
          end else begin
            cnt_q = cnt_q + CFG_W'(1);
            if (cnt_q >= cfg_q[REG_RISE_LIMIT]) presence_end(1'b1, res);
          end
        end
        ST_RD_SAMPLE: begin
          if (line) rx_q[bit_q] = 1'b1;
          if (cfg_q[REG_READ_TAIL] == '0) res.done = slot_end(ST_RD_LOW);
          else go_to(ST_RD_TAIL);
        end
        default: begin
          cnt_q = cnt_q + CFG_W'(1);
          if (cnt_q >= phase_ticks(st_q)) begin
            case (st_q)
              ST_RST_LOW: begin
                if (cfg_q[REG_RESET_RELEASE] == '0) go_to(ST_FALL_WATCH);
                else go_to(ST_RST_REL);
              end
              ST_RST_REL: go_to(ST_FALL_WATCH);
              ST_WR_LOW:  go_to(ST_WR_HIGH);
              ST_WR_HIGH: begin
                tx_q     = tx_q >> 1;
                res.done = slot_end(ST_WR_LOW);
              end
              ST_RD_LOW: begin
                if (cfg_q[REG_READ_SAMPLE] == '0) go_to(ST_RD_SAMPLE);
                else go_to(ST_RD_WAIT);
              end
              ST_RD_WAIT: go_to(ST_RD_SAMPLE);
              ST_RD_TAIL: res.done = slot_end(ST_RD_LOW);
              default:    go_to(ST_IDLE);
            endcase
          end
        end
      endcase
    end
    res.busy           = (st_q != ST_IDLE);
    res.read_value     = rx_q;
    res.presence_error = err_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_ni) begin
      cfg_q[REG_RESET_LOW]     = CFG_W'(480);
      cfg_q[REG_RESET_RELEASE] = CFG_W'(15);
      cfg_q[REG_FALL_LIMIT]    = CFG_W'(200);
      cfg_q[REG_RISE_LIMIT]    = CFG_W'(240);
      cfg_q[REG_SHORT_PHASE]   = CFG_W'(2);
      cfg_q[REG_LONG_PHASE]    = CFG_W'(60);
      cfg_q[REG_READ_SAMPLE]   = CFG_W'(12);
      cfg_q[REG_READ_TAIL]     = CFG_W'(50);
      st_q  = ST_IDLE;
      cnt_q = '0;
      bit_q = '0;
      tx_q  = '0;
      rx_q  = '0;
      err_q = 1'b0;
      bus_result_q.delete();
      owed_n = 0;
    end else begin
      if (cfg_we_i) cfg_q[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        bus_result_q.push_back(advance_bus(mode_i, write_data_i, line_level_i));
      end
      if (out_valid_i && out_ready_i) begin
        got.drive_low      = drive_low_i;
        got.busy           = busy_res_i;
        got.done           = done_res_i;
        got.read_value     = read_value_i;
        got.presence_error = presence_error_i;
        if (bus_result_q.size() == 0) begin
          fail_n++;
          if (fail_n <= REPORT_MAX) begin
            $display("%0t: result with no request pending: drive=%b busy=%b done=%b rd=%h perr=%b",
                     $realtime, got.drive_low, got.busy, got.done, got.read_value,
                     got.presence_error);
          end
        end else begin
          want = bus_result_q.pop_front();
          if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
              got.done !== want.done || got.read_value !== want.read_value ||
              got.presence_error !== want.presence_error) begin
            fail_n++;
            if (fail_n <= REPORT_MAX) begin
              $display("%0t: mismatch exp drive=%b busy=%b done=%b rd=%h perr=%b",
                       $realtime, want.drive_low, want.busy, want.done, want.read_value,
                       want.presence_error);
              $display("%0t:          got drive=%b busy=%b done=%b rd=%h perr=%b",
                       $realtime, got.drive_low, got.busy, got.done, got.read_value,
                       got.presence_error);
            end
          end
        end
      end
      owed_n = bus_result_q.size();
    end
  end

endmodule

@@ test/tb_one_wire_bus_master_top.sv @@
`timescale 1ns / 100ps
module tb_one_wire_bus_master_top;
  import owbm_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS  = 450;

  // Line level choice for write and read slots
  localparam int LVL_RANDOM = 0;
  localparam int LVL_HIGH   = 1;
  localparam int LVL_LOW    = 2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = MODE_TICK;
  logic [7:0]           write_data = '0;
  logic                 line_level = 1'b1;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 drive_low;
  logic                 busy_res;
  logic                 done_res;
  logic [7:0]           read_value;
  logic                 presence_error;

  int                   fail_cnt;
  int                   owed_cnt;
  int                   send_idle = 0;
  int                   recv_stall = 0;
  int                   quiet_cycles = 0;
  logic [CFG_W-1:0]     cur_cfg [CFG_NUM];

  one_wire_bus_master_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .write_data_i    (write_data),
    .line_level_i    (line_level),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .drive_low_o     (drive_low),
    .busy_res_o      (busy_res),
    .done_res_o      (done_res),
    .read_value_o    (read_value),
    .presence_error_o(presence_error)
  );

  owbm_result_check u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .write_data_i    (write_data),
    .line_level_i    (line_level),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .drive_low_i     (drive_low),
    .busy_res_i      (busy_res),
    .done_res_i      (done_res),
    .read_value_i    (read_value),
    .presence_error_i(presence_error),
    .fail_cnt_o      (fail_cnt),
    .owed_cnt_o      (owed_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_one_wire_bus_master_top failed");
      $finish;
    end
  end

  function automatic int at_least_one(logic [CFG_W-1:0] v);
    return (v == '0) ? 1 : int'(v);
  endfunction

  task automatic send_tick(input logic [1:0] m, input logic [7:0] wd, input logic lvl);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    write_data <= wd;
    line_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all results, let the engine settle, then load cur_cfg.
  task automatic write_cfg();
    int i;
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    for (i = 0; i < CFG_NUM; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= cur_cfg[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One command plus the ticks that carry it to its end. For a bus reset the
  // device holds the line high for hi_ticks, then low for lo_ticks+1, then high.
  task automatic run_op(input logic [1:0] op, input logic [7:0] wd, input int hi_ticks,
                        input int lo_ticks, input int lvl_sel, output int n);
    int lead;
    int t;
    int w;
    int short1;
    logic [1:0] m;
    logic [7:0] d;
    logic lvl;
    short1 = at_least_one(cur_cfg[REG_SHORT_PHASE]);
    case (op)
      MODE_RESET: begin
        lead = at_least_one(cur_cfg[REG_RESET_LOW]) + int'(cur_cfg[REG_RESET_RELEASE]);
        n    = lead + hi_ticks + lo_ticks + 2;
      end
      MODE_WRITE: begin
        n    = 8 * (short1 + at_least_one(cur_cfg[REG_LONG_PHASE]));
        lead = n;
      end
      MODE_READ: begin
        n    = 8 * (short1 + int'(cur_cfg[REG_READ_SAMPLE]) + 1 +
                    int'(cur_cfg[REG_READ_TAIL]));
        lead = n;
      end
      default: begin
        n    = 1;
        lead = 1;
      end
    endcase
    for (t = 0; t < n; t++) begin
      // commands while surely busy must be ignored
      if (t == 0) m = op;
      else if (t < lead && $urandom_range(3) == 0) m = 2'($urandom_range(3));
      else m = MODE_TICK;
      d = (t == 0) ? wd : 8'($urandom);
      if (op == MODE_RESET) begin
        w = t - lead;
        if (w < 0) lvl = 1'($urandom);
        else lvl = !(w >= hi_ticks && w <= hi_ticks + lo_ticks);
      end else begin
        case (lvl_sel)
          LVL_HIGH: lvl = 1'b1;
          LVL_LOW:  lvl = 1'b0;
          default:  lvl = 1'($urandom);
        endcase
      end
      send_tick(m, d, lvl);
    end
  endtask

  task automatic random_chunk(input int target);
    int i;
    int items;
    int n;
    int pick;
    int f;
    int r;
    for (i = 0; i < CFG_NUM; i++) begin
      if ($urandom_range(9) == 0) cur_cfg[i] = CFG_W'($urandom_range(5, 12));
      else cur_cfg[i] = CFG_W'($urandom_range(0, 4));
    end
    write_cfg();
    items = 0;
    while (items < target) begin
      pick = $urandom_range(99);
      f    = $urandom_range(0, at_least_one(cur_cfg[REG_FALL_LIMIT]));
      r    = $urandom_range(0, at_least_one(cur_cfg[REG_RISE_LIMIT]));
      if (pick < 30) run_op(MODE_RESET, 8'($urandom), f, r, LVL_RANDOM, n);
      else if (pick < 65) run_op(MODE_WRITE, 8'($urandom), 0, 0, LVL_RANDOM, n);
      else run_op(MODE_READ, 8'($urandom), 0, 0, LVL_RANDOM, n);
      items += n;
      if ($urandom_range(99) < 40) begin
        repeat ($urandom_range(1, 3)) run_op(MODE_TICK, 8'($urandom), 0, 0, LVL_RANDOM, n);
      end
    end
  endtask

  initial begin
    int i;
    int n;
    int ph;
    cur_cfg[REG_RESET_LOW]     = CFG_W'(480);
    cur_cfg[REG_RESET_RELEASE] = CFG_W'(15);
    cur_cfg[REG_FALL_LIMIT]    = CFG_W'(200);
    cur_cfg[REG_RISE_LIMIT]    = CFG_W'(240);
    cur_cfg[REG_SHORT_PHASE]   = CFG_W'(2);
    cur_cfg[REG_LONG_PHASE]    = CFG_W'(60);
    cur_cfg[REG_READ_SAMPLE]   = CFG_W'(12);
    cur_cfg[REG_READ_TAIL]     = CFG_W'(50);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // an idle tick at reset values, then the degenerate all-zero setting
    run_op(MODE_TICK, 8'hFF, 0, 0, LVL_LOW, n);
    for (i = 0; i < CFG_NUM; i++) cur_cfg[i] = '0;
    write_cfg();
    run_op(MODE_TICK, 8'h00, 0, 0, LVL_HIGH, n);
    run_op(MODE_RESET, 8'h00, 0, 0, LVL_RANDOM, n);
    run_op(MODE_RESET, 8'hFF, 1, 0, LVL_RANDOM, n);
    run_op(MODE_RESET, 8'h5A, 0, 1, LVL_RANDOM, n);
    run_op(MODE_WRITE, 8'h00, 0, 0, LVL_LOW, n);
    run_op(MODE_WRITE, 8'hFF, 0, 0, LVL_HIGH, n);
    run_op(MODE_READ, 8'h00, 0, 0, LVL_HIGH, n);
    run_op(MODE_READ, 8'hFF, 0, 0, LVL_LOW, n);
    run_op(MODE_TICK, 8'h81, 0, 0, LVL_RANDOM, n);

    // presence limits at their top value, everything else minimal
    cur_cfg[REG_FALL_LIMIT] = '1;
    cur_cfg[REG_RISE_LIMIT] = '1;
    write_cfg();
    run_op(MODE_RESET, 8'h00, 2, 3, LVL_RANDOM, n);
    run_op(MODE_RESET, 8'h00, 0, 0, LVL_RANDOM, n);
    run_op(MODE_WRITE, 8'($urandom), 0, 0, LVL_RANDOM, n);
    run_op(MODE_READ, 8'h00, 0, 0, LVL_RANDOM, n);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 63; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 63; end
        default: begin send_idle = 15; recv_stall = 15; end
      endcase
      repeat (2) random_chunk(RANDOM_ITEMS / 12);
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("tb_one_wire_bus_master_top passed");
    end else begin
      $display("tb_one_wire_bus_master_top failed");
    end
    $finish;
  end

endmodule
